// ===== design/rf_cavity_momentum_kick_top_defines.svh =====
// Assertion macros used by the top module.
`ifndef RF_CAVITY_MOMENTUM_KICK_TOP_DEFINES_SVH
`define RF_CAVITY_MOMENTUM_KICK_TOP_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define RFCK_ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define RFCK_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== design/rfck_pkg.sv =====
`timescale 1ns / 1ps
package rfck_pkg;

	localparam int DATA_W = 32;
	localparam int CORDIC_W = 34;

	localparam logic [1:0] REG_KICK_GAIN = 2'd0;
	localparam logic [1:0] REG_WAVE_TURNS = 2'd1;
	localparam logic [1:0] REG_SIN_PHASE = 2'd2;
	localparam logic [1:0] REG_COS_PHASE = 2'd3;

	localparam logic signed [DATA_W-1:0] ONE_Q30 = 32'sh4000_0000;
	localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;

	typedef logic signed [CORDIC_W-1:0] cordic_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] gain;
		logic signed [DATA_W-1:0] sin_ph;
		logic signed [DATA_W-1:0] cos_ph;
	} kick_cfg_t;

	function automatic logic [31:0] atan_turns(input logic [4:0] idx);
		logic [31:0] r;
		unique case (idx)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			5'd30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] clamp_unit(input logic signed [DATA_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > ONE_Q30) begin
			r = ONE_Q30;
		end else if (v < -ONE_Q30) begin
			r = -ONE_Q30;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== design/rfck_cordic.sv =====
`timescale 1ns / 1ps
module rfck_cordic
	import rfck_pkg::*;
#(
	parameter int STAGES = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [31:0] phase,
	output logic        out_valid,
	output cordic_t     sine
);

	localparam int N = (STAGES > 32) ? 32 : STAGES;

	logic    v_s [N+1];
	cordic_t x_s [N+1];
	cordic_t y_s [N+1];
	cordic_t z_s [N+1];

	logic signed [CORDIC_W-1:0] a_c;
	logic signed [CORDIC_W-1:0] z_c;

	// Fold the phase into a quarter turn around zero; the sine is unchanged.
	always_comb begin
		a_c = CORDIC_W'($signed(phase));
		if (a_c > 34'sh0_4000_0000) begin
			z_c = 34'sh0_8000_0000 - a_c;
		end else if (a_c < -34'sh0_4000_0000) begin
			z_c = -34'sh0_8000_0000 - a_c;
		end else begin
			z_c = a_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CORDIC_START;
			y_s[0] <= '0;
			z_s[0] <= z_c;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		cordic_t ang;
		assign ang = $signed({2'b00, atan_turns(5'(i))});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][CORDIC_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ang;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ang;
				end
			end
		end
	end

	assign out_valid = v_s[N];
	assign sine = y_s[N];

endmodule

// ===== design/rfck_kick.sv =====
`timescale 1ns / 1ps
module rfck_kick
	import rfck_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  kick_cfg_t   cfg,
	input  logic        in_valid,
	input  cordic_t     s_full,
	input  cordic_t     s_half,
	input  logic [31:0] momentum,
	output logic        out_valid,
	output logic [31:0] momentum_out
);

	logic               v_s1, v_s2, v_s3;
	logic signed [33:0] sq_s1;
	cordic_t            sf_s1;
	logic [31:0]        mom_s1, mom_s2, mom_s3;
	logic signed [35:0] t1_s2, t2_s2;
	logic signed [39:0] kick_s3;

	logic signed [67:0] sq_p;
	logic signed [65:0] t1_p, t2_p;
	logic signed [37:0] br_c;
	logic signed [69:0] kick_p;
	logic signed [40:0] sum_c;

	assign sq_p = s_half * s_half;
	assign t1_p = sf_s1 * cfg.cos_ph;
	assign t2_p = sq_s1 * cfg.sin_ph;
	assign br_c = 38'(t1_s2) - (38'(t2_s2) <<< 1);
	assign kick_p = br_c * cfg.gain;
	assign sum_c = 41'($signed(mom_s3)) + 41'(kick_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1 <= sq_p[63:30];
			sf_s1 <= s_full;
			mom_s1 <= momentum;
			t1_s2 <= t1_p[65:30];
			t2_s2 <= t2_p[65:30];
			mom_s2 <= mom_s1;
			kick_s3 <= kick_p[69:30];
			mom_s3 <= mom_s2;
			if (sum_c > 41'sh0_7FFF_FFFF) begin
				momentum_out <= 32'h7FFF_FFFF;
			end else if (sum_c < -41'sh0_8000_0000) begin
				momentum_out <= 32'h8000_0000;
			end else begin
				momentum_out <= sum_c[31:0];
			end
		end
	end

endmodule

// ===== design/rf_cavity_momentum_kick_top.sv =====
`timescale 1ns / 1ps
// Thin RF cavity kick: one particle (z, pz) per cycle in, one kicked pz out. The pipeline runs
// through the phase multiply, the two parallel pipelined CORDIC sine units (a fold, then one
// stage per rotation), three product stages and the saturating sum. The whole pipeline holds
// while a result waits on m_tready. Registers must only be written while the pipeline is
// empty.
`include "rf_cavity_momentum_kick_top_defines.svh"
module rf_cavity_momentum_kick_top
	import rfck_pkg::*;
#(
	parameter int SINE_STAGES = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // position [31:0], momentum [63:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // momentum_out [31:0]
);

	localparam int N = (SINE_STAGES > 32) ? 32 : SINE_STAGES;

	logic [31:0] gain_q, wave_q, sin_q, cos_q;
	logic        en;
	kick_cfg_t   cfg;

	logic        v_s1;
	logic [31:0] ph_full_s1, ph_half_s1, mom_s1;
	logic [31:0] mom_d_s [N+1];
	logic signed [64:0] prod_c;

	logic        vf, vh;
	cordic_t     sf, sh;

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
			wave_q <= '0;
			sin_q <= '0;
			cos_q <= ONE_Q30;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KICK_GAIN: gain_q <= cfg_data;
				REG_WAVE_TURNS: wave_q <= cfg_data;
				REG_SIN_PHASE: sin_q <= cfg_data;
				REG_COS_PHASE: cos_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.gain = $signed(gain_q);
	assign cfg.sin_ph = clamp_unit($signed(sin_q));
	assign cfg.cos_ph = clamp_unit($signed(cos_q));

	assign prod_c = $signed({s_tdata[31], s_tdata[31:0]}) * $signed({1'b0, wave_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_full_s1 <= prod_c[39:8];
			ph_half_s1 <= prod_c[40:9];
			mom_s1 <= s_tdata[63:32];
			mom_d_s[0] <= mom_s1;
			for (int i = 0; i < N; i++) begin
				mom_d_s[i+1] <= mom_d_s[i];
			end
		end
	end

	rfck_cordic #(.STAGES(SINE_STAGES)) u_sin_full (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.phase(ph_full_s1), .out_valid(vf), .sine(sf)
	);

	rfck_cordic #(.STAGES(SINE_STAGES)) u_sin_half (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.phase(ph_half_s1), .out_valid(vh), .sine(sh)
	);

	rfck_kick u_kick (
		.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg),
		.in_valid(vf), .s_full(sf), .s_half(sh), .momentum(mom_d_s[N]),
		.out_valid(m_tvalid), .momentum_out(m_tdata)
	);

	`RFCK_ASSERT_IMP(a_units_aligned, 1'b1, vf == vh, "Sine units out of step.")
	`RFCK_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready, "Input refused while output is empty.")
	`RFCK_ASSERT_NEXT(a_stall_holds_pipe, m_tvalid && !m_tready, $stable(vf) && $stable(v_s1),
		"Pipeline moved during an output stall.")

endmodule

// ===== sim/tb_rf_cavity_momentum_kick_top.sv =====
`timescale 1ns / 1ps
module tb_rf_cavity_momentum_kick_top;
	import rfck_pkg::*;

	localparam int STAGES = 24;
	localparam int LATENCY = STAGES + 6;
	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_KICK_GAIN;
	logic [31:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	rf_cavity_momentum_kick_top #(.SINE_STAGES(STAGES)) dut (.*);

	always #5 clk = ~clk;

	// Local copy of the registers.
	logic signed [31:0] gain_reg, sin_reg, cos_reg;
	logic [31:0] turns_reg;

	logic [31:0] kicked_momentum_q[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;

	function automatic longint floor_shift(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint q30_mul(input longint a, input longint b);
		return floor_shift(a * b, 30);
	endfunction

	function automatic longint unit_clamp(input longint v);
		if (v > 64'sd1073741824) return 64'sd1073741824;
		if (v < -64'sd1073741824) return -64'sd1073741824;
		return v;
	endfunction

	function automatic longint cordic_sine(input logic [31:0] phase);
		longint a, x, y, z, dx, dy;
		int n;
		a = longint'($signed(phase));
		x = longint'(CORDIC_START);
		y = 0;
		n = STAGES > 32 ? 32 : STAGES;
		if (a > 64'sd1073741824) a = 64'sd2147483648 - a;
		else if (a < -64'sd1073741824) a = -64'sd2147483648 - a;
		z = a;
		for (int i = 0; i < n; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_turns(i[4:0]));
			end else begin
				x += dx; y -= dy; z += longint'(atan_turns(i[4:0]));
			end
		end
		return y;
	endfunction

	function automatic logic [31:0] kick_momentum(input logic [31:0] pos, input logic [31:0] mom);
		logic [63:0] prod;
		longint s_full, s_half, sq, bracket, kick, sum;
		prod = 64'(longint'($signed(pos))) * {32'd0, turns_reg};
		s_full = cordic_sine(prod[39:8]);
		s_half = cordic_sine(prod[40:9]);
		sq = q30_mul(s_half, s_half);
		bracket = q30_mul(s_full, unit_clamp(longint'(cos_reg)))
			- 2 * q30_mul(unit_clamp(longint'(sin_reg)), sq);
		kick = q30_mul(longint'(gain_reg), bracket);
		sum = longint'($signed(mom)) + kick;
		if (sum > 64'sd2147483647) sum = 64'sd2147483647;
		if (sum < -64'sd2147483648) sum = -64'sd2147483648;
		return sum[31:0];
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_KICK_GAIN: gain_reg = val;
			REG_WAVE_TURNS: turns_reg = val;
			REG_SIN_PHASE: sin_reg = val;
			default: cos_reg = val;
		endcase
	endtask

	task automatic set_regs(input logic [31:0] g, input logic [31:0] w, input logic [31:0] s,
			input logic [31:0] c);
		s_tvalid <= 1'b0;
		wait (kicked_momentum_q.size() == 0);
		repeat (LATENCY + 4) @(negedge clk);
		write_reg(REG_KICK_GAIN, g);
		write_reg(REG_WAVE_TURNS, w);
		write_reg(REG_SIN_PHASE, s);
		write_reg(REG_COS_PHASE, c);
	endtask

	// Sends one particle; called and returning at a falling edge.
	task automatic send_particle(input logic [31:0] pos, input logic [31:0] mom);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {mom, pos};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		kicked_momentum_q.push_back(kick_momentum(pos, mom));
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_field();
		case ($urandom_range(5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom_range(255) - 128;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_phase_reg();
		case ($urandom_range(5))
			0: return 32'h4000_0000;
			1: return 32'hc000_0000;
			2: return $urandom;
			default: return $urandom_range(32'h7fff_ffff) - 32'h4000_0000;
		endcase
	endfunction

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (kicked_momentum_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_tdata);
				errors++;
			end else begin
				if (m_tdata !== kicked_momentum_q[0]) begin
					$display("%0t: momentum_out mismatch expected %h actual %h", $time,
						kicked_momentum_q[0], m_tdata);
					errors++;
				end
				void'(kicked_momentum_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic test_reset_defaults();
		gain_reg = '0;
		turns_reg = '0;
		sin_reg = '0;
		cos_reg = 32'h4000_0000;
		send_particle(32'h1234_5678, 32'h7fff_ffff);
		send_particle(32'h8000_0000, 32'h8000_0000);
		send_particle(32'h7fff_ffff, 32'h0000_0000);
	endtask

	task automatic test_directed_extremes();
		set_regs(32'h7fff_ffff, 32'hffff_ffff, 32'h4000_0000, 32'h4000_0000);
		send_particle(32'h7fff_ffff, 32'h7fff_ffff);
		send_particle(32'h8000_0000, 32'h8000_0000);
		send_particle(32'h0100_0000, 32'h0);
		set_regs(32'h8000_0000, 32'h0001_0000, 32'hc000_0000, 32'hc000_0000);
		for (int k = 0; k < 8; k++) send_particle(32'h0020_0000 * k, 32'h7000_0000);
		send_particle(32'hffc0_0000, 32'h8000_0000);
		// Phase registers outside the unit range are clamped.
		set_regs(32'h4000_0000, 32'h0003_8000, 32'h7fff_ffff, 32'h8000_0000);
		send_particle(32'h00c0_0000, 32'h7fff_ff00);
		send_particle(32'hff40_0000, 32'h8000_0100);
		send_particle(32'h1234_5678, 32'h0);
	endtask

	task automatic test_random_phases(input int n_items);
		for (int k = 0; k < n_items; k++) begin
			if (k % 100 == 0)
				set_regs($urandom_range(9) == 0 ? 32'h0 : rand_field(), rand_field(),
					rand_phase_reg(), rand_phase_reg());
			if (k % 100 == 50) hold_cycles = 120;
			send_particle(rand_field(), rand_field());
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 28;
		recv_idle_pct = 78;
		test_reset_defaults();
		test_directed_extremes();
		test_random_phases(500);
		send_idle_pct = 78;
		recv_idle_pct = 28;
		test_random_phases(500);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_phases(600);
		s_tvalid <= 1'b0;
		wait (kicked_momentum_q.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+design
design/rfck_pkg.sv
design/rfck_cordic.sv
design/rfck_kick.sv
design/rf_cavity_momentum_kick_top.sv
sim/tb_rf_cavity_momentum_kick_top.sv
